[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sssc_pkg.sv]
// Shared types and constants of the spiral scan coordinate generator.
package sssc_pkg;

    localparam int DIM_CFG_W   = 11;
    localparam int START_W     = 10;
    localparam int ROW_OUT_W   = 10;
    localparam int INDEX_OUT_W = 20;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_GRID_ROWS = 2'd0;
    localparam t_reg_idx REG_GRID_COLS = 2'd1;
    localparam t_reg_idx REG_START_ROW = 2'd2;
    localparam t_reg_idx REG_START_COL = 2'd3;

    localparam logic [DIM_CFG_W-1:0] GRID_DIM_RESET = 11'd1;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] grid_rows;
        logic [DIM_CFG_W-1:0] grid_cols;
        logic [START_W-1:0]   start_row;
        logic [START_W-1:0]   start_col;
    } t_cfg;

endpackage

[hw/rtl/spiral_scan_coordinate_generator.sv]
// Top level: clockwise square-spiral walk over a configured grid.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------------
//  config    in/out     psel/penable/pready       paddr, pwdata, prdata
//  step      in         i_in_valid/o_in_ready     i_restart
//  cell      out        o_out_valid/i_out_ready   o_cell_row/col/index, o_last
//
// One step transaction is taken every cycle while o_in_ready is high; the walk state
// advances in the cycle it is accepted; an in-grid cell is output in the next cycle.
// The walk-state update (grid bounds, count compare, ring move) is the only loop.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds o_in_ready low until the cell transaction is taken.
`include "assert_macros.svh"

module spiral_scan_coordinate_generator #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sssc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [sssc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [sssc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sssc_pkg::ROW_OUT_W-1:0]        o_cell_row,
    output logic [sssc_pkg::ROW_OUT_W-1:0]        o_cell_col,
    output logic [sssc_pkg::INDEX_OUT_W-1:0]      o_cell_index,
    output logic                                  o_last
);

    localparam int RING_LIMIT = 4 * MAX_DIM;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int POS_W      = $clog2(RING_LIMIT + (2 ** sssc_pkg::START_W) + 3) + 1;
    localparam int LEN_W      = $clog2(8 * RING_LIMIT + 13);
    localparam int CNT_W      = $clog2(MAX_DIM * MAX_DIM + 1);

    localparam logic signed [POS_W-1:0] LIM_HI = POS_W'(RING_LIMIT);
    localparam logic signed [POS_W-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [POS_W-1:0] POS_ZERO = POS_W'(0);
    localparam logic [LEN_W-1:0]        LEN_FIRST = LEN_W'(4);
    localparam logic [LEN_W-1:0]        LEN_GROW  = LEN_W'(8);

    sssc_pkg::t_cfg w_cfg;

    sssc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // walk state
    logic signed [POS_W-1:0] r_walk_row, r_walk_col;
    logic signed [POS_W-1:0] r_ring_top, r_ring_bottom, r_ring_left, r_ring_right;
    logic [LEN_W-1:0]        r_ring_length, r_ring_step;
    logic [CNT_W-1:0]        r_count;
    logic                    r_finished;

    logic signed [POS_W-1:0] n_walk_row, n_walk_col;
    logic signed [POS_W-1:0] n_ring_top, n_ring_bottom, n_ring_left, n_ring_right;
    logic [LEN_W-1:0]        n_ring_length, n_ring_step;
    logic [CNT_W-1:0]        n_count;
    logic                    n_finished;

    // state after an optional restart reload
    logic signed [POS_W-1:0] e_walk_row, e_walk_col;
    logic signed [POS_W-1:0] e_ring_top, e_ring_bottom, e_ring_left, e_ring_right;
    logic [LEN_W-1:0]        e_ring_length, e_ring_step;
    logic [CNT_W-1:0]        e_count;
    logic                    e_finished;

    // output register
    logic                              r_out_valid;
    logic [sssc_pkg::ROW_OUT_W-1:0]    r_cell_row, r_cell_col;
    logic [sssc_pkg::INDEX_OUT_W-1:0]  r_cell_index;
    logic                              r_last;

    logic [DIM_W-1:0]        w_rows, w_cols;
    logic [CNT_W-1:0]        w_total;
    logic signed [POS_W-1:0] w_rows_s, w_cols_s;
    logic signed [POS_W-1:0] w_start_row, w_start_col;
    logic                    w_accept, w_active, w_emit;
    logic [CNT_W-1:0]        w_count_inc;
    logic [LEN_W-1:0]        w_step_inc;
    logic signed [POS_W-1:0] w_top_dn, w_bottom_up, w_left_dn, w_right_up;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // saturate the grid size at the largest supported dimension
    always_comb begin
        if (32'(w_cfg.grid_rows) > MAX_DIM) begin
            w_rows = DIM_W'(MAX_DIM);
        end else begin
            w_rows = DIM_W'(w_cfg.grid_rows);
        end
        if (32'(w_cfg.grid_cols) > MAX_DIM) begin
            w_cols = DIM_W'(MAX_DIM);
        end else begin
            w_cols = DIM_W'(w_cfg.grid_cols);
        end
    end

    assign w_total     = CNT_W'(w_rows) * CNT_W'(w_cols);
    assign w_rows_s    = POS_W'(w_rows);
    assign w_cols_s    = POS_W'(w_cols);
    assign w_start_row = POS_W'(w_cfg.start_row);
    assign w_start_col = POS_W'(w_cfg.start_col);

    always_comb begin
        if (i_restart) begin
            e_walk_row    = w_start_row;
            e_walk_col    = w_start_col;
            e_ring_top    = w_start_row;
            e_ring_bottom = w_start_row + POS_W'(2);
            e_ring_left   = w_start_col;
            e_ring_right  = w_start_col + POS_W'(2);
            e_ring_length = LEN_FIRST;
            e_ring_step   = '0;
            e_count       = '0;
            e_finished    = 1'b0;
        end else begin
            e_walk_row    = r_walk_row;
            e_walk_col    = r_walk_col;
            e_ring_top    = r_ring_top;
            e_ring_bottom = r_ring_bottom;
            e_ring_left   = r_ring_left;
            e_ring_right  = r_ring_right;
            e_ring_length = r_ring_length;
            e_ring_step   = r_ring_step;
            e_count       = r_count;
            e_finished    = r_finished;
        end
    end

    assign w_active = (w_total != '0) && (e_count < w_total) && !e_finished;
    assign w_emit   = w_active && (e_walk_row >= POS_ZERO) && (e_walk_row < w_rows_s)
                      && (e_walk_col >= POS_ZERO) && (e_walk_col < w_cols_s);

    assign w_count_inc = e_count + CNT_W'(1);
    assign w_step_inc  = e_ring_step + LEN_W'(1);
    assign w_top_dn    = e_ring_top - POS_W'(1);
    assign w_bottom_up = e_ring_bottom + POS_W'(1);
    assign w_left_dn   = e_ring_left - POS_W'(1);
    assign w_right_up  = e_ring_right + POS_W'(1);

    always_comb begin
        n_walk_row    = e_walk_row;
        n_walk_col    = e_walk_col;
        n_ring_top    = e_ring_top;
        n_ring_bottom = e_ring_bottom;
        n_ring_left   = e_ring_left;
        n_ring_right  = e_ring_right;
        n_ring_length = e_ring_length;
        n_ring_step   = e_ring_step;
        n_count       = e_count;
        n_finished    = e_finished;
        if (w_total != '0 && !e_finished && e_count >= w_total) begin
            n_finished = 1'b1;
        end
        if (w_active) begin
            if (w_emit) begin
                n_count = w_count_inc;
                if (w_count_inc >= w_total) begin
                    n_finished = 1'b1;
                end
            end
            // ring done: widen by one on every side, enter one row above the bottom
            priority if (w_step_inc >= e_ring_length) begin
                n_ring_top    = w_top_dn;
                n_ring_bottom = w_bottom_up;
                n_ring_left   = w_left_dn;
                n_ring_right  = w_right_up;
                n_walk_row    = e_ring_bottom - POS_W'(1);
                n_walk_col    = w_left_dn;
                n_ring_length = e_ring_length + LEN_GROW;
                n_ring_step   = '0;
                if (w_top_dn < LIM_LO || w_left_dn < LIM_LO
                    || w_bottom_up > LIM_HI || w_right_up > LIM_HI) begin
                    n_finished = 1'b1;
                end
            end else if (e_walk_row == e_ring_top && e_walk_col < e_ring_right - POS_W'(1)) begin
                n_ring_step = w_step_inc;
                n_walk_col  = e_walk_col + POS_W'(1);
            end else if (e_walk_col == e_ring_right - POS_W'(1)
                         && e_walk_row < e_ring_bottom - POS_W'(1)) begin
                n_ring_step = w_step_inc;
                n_walk_row  = e_walk_row + POS_W'(1);
            end else if (e_walk_row == e_ring_bottom - POS_W'(1) && e_walk_col > e_ring_left) begin
                n_ring_step = w_step_inc;
                n_walk_col  = e_walk_col - POS_W'(1);
            end else begin
                n_ring_step = w_step_inc;
                n_walk_row  = e_walk_row - POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_row    <= '0;
            r_walk_col    <= '0;
            r_ring_top    <= '0;
            r_ring_bottom <= POS_W'(2);
            r_ring_left   <= '0;
            r_ring_right  <= POS_W'(2);
            r_ring_length <= LEN_FIRST;
            r_ring_step   <= '0;
            r_count       <= '0;
            r_finished    <= 1'b0;
        end else if (w_accept) begin
            r_walk_row    <= n_walk_row;
            r_walk_col    <= n_walk_col;
            r_ring_top    <= n_ring_top;
            r_ring_bottom <= n_ring_bottom;
            r_ring_left   <= n_ring_left;
            r_ring_right  <= n_ring_right;
            r_ring_length <= n_ring_length;
            r_ring_step   <= n_ring_step;
            r_count       <= n_count;
            r_finished    <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the cell transaction
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_cell_row   <= sssc_pkg::ROW_OUT_W'(e_walk_row);
            r_cell_col   <= sssc_pkg::ROW_OUT_W'(e_walk_col);
            r_cell_index <= sssc_pkg::INDEX_OUT_W'(e_count);
            r_last       <= (w_count_inc == w_total);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_row   = r_cell_row;
    assign o_cell_col   = r_cell_col;
    assign o_cell_index = r_cell_index;
    assign o_last       = r_last;

    `SSSC_ASSERT_NEXT(a_no_cell_after_finish, i_clk, i_rst_n,
        w_accept && r_finished && !i_restart, !o_out_valid,
        "cell emitted after the walk finished")
    `SSSC_ASSERT_NOW(a_last_marks_finish, i_clk, i_rst_n,
        o_out_valid && o_last, r_finished,
        "last cell pending but walk not finished")
    `SSSC_ASSERT_NOW(a_ring_square, i_clk, i_rst_n,
        1'b1, (r_ring_bottom - r_ring_top) == (r_ring_right - r_ring_left),
        "ring bounds are not square")
    `SSSC_ASSERT_NOW(a_step_in_ring, i_clk, i_rst_n,
        1'b1, r_ring_step < r_ring_length,
        "ring step ran past the ring length")

endmodule

[hw/rtl/sssc_cfg.sv]
// APB register file holding the grid size and spiral start cell.
module sssc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sssc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sssc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sssc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output sssc_pkg::t_cfg                   o_cfg
);

    sssc_pkg::t_cfg   r_cfg;
    sssc_pkg::t_cfg   n_cfg;
    sssc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                sssc_pkg::REG_GRID_ROWS: n_cfg.grid_rows = pwdata[sssc_pkg::DIM_CFG_W-1:0];
                sssc_pkg::REG_GRID_COLS: n_cfg.grid_cols = pwdata[sssc_pkg::DIM_CFG_W-1:0];
                sssc_pkg::REG_START_ROW: n_cfg.start_row = pwdata[sssc_pkg::START_W-1:0];
                sssc_pkg::REG_START_COL: n_cfg.start_col = pwdata[sssc_pkg::START_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows <= sssc_pkg::GRID_DIM_RESET;
            r_cfg.grid_cols <= sssc_pkg::GRID_DIM_RESET;
            r_cfg.start_row <= '0;
            r_cfg.start_col <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            sssc_pkg::REG_GRID_ROWS: prdata = sssc_pkg::APB_DATA_W'(r_cfg.grid_rows);
            sssc_pkg::REG_GRID_COLS: prdata = sssc_pkg::APB_DATA_W'(r_cfg.grid_cols);
            sssc_pkg::REG_START_ROW: prdata = sssc_pkg::APB_DATA_W'(r_cfg.start_row);
            sssc_pkg::REG_START_COL: prdata = sssc_pkg::APB_DATA_W'(r_cfg.start_col);
        endcase
    end

endmodule

[tb/tb_spiral_scan_coordinate_generator.sv]
// Testbench for the spiral scan coordinate generator: APB setup, step stimulus, cell checking.
`timescale 1ns / 100ps

module tb_spiral_scan_coordinate_generator;

    localparam int unsigned MAX_DIM     = 1024;
    localparam int          RING_LIMIT  = 4 * MAX_DIM;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 4;
    localparam int          RANDOM_STEPS = 430;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_PATTERN,
        SINK_SPARSE
    } t_sink_mode;

    typedef struct {
        logic [sssc_pkg::ROW_OUT_W-1:0]   row;
        logic [sssc_pkg::ROW_OUT_W-1:0]   col;
        logic [sssc_pkg::INDEX_OUT_W-1:0] index;
        logic                             last;
    } t_cell;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [sssc_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [sssc_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [sssc_pkg::APB_DATA_W-1:0]    prdata;
    logic                               pready;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_restart = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [sssc_pkg::ROW_OUT_W-1:0]     o_cell_row;
    logic [sssc_pkg::ROW_OUT_W-1:0]     o_cell_col;
    logic [sssc_pkg::INDEX_OUT_W-1:0]   o_cell_index;
    logic                               o_last;

    spiral_scan_coordinate_generator #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_restart(i_restart),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cell_row(o_cell_row),
        .o_cell_col(o_cell_col),
        .o_cell_index(o_cell_index),
        .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    // Register copies and walk state of the spiral predictor
    logic [sssc_pkg::DIM_CFG_W-1:0] cfg_rows;
    logic [sssc_pkg::DIM_CFG_W-1:0] cfg_cols;
    logic [sssc_pkg::START_W-1:0]   cfg_srow;
    logic [sssc_pkg::START_W-1:0]   cfg_scol;

    int          spiral_row;
    int          spiral_col;
    int          ring_top;
    int          ring_bot;
    int          ring_lft;
    int          ring_rgt;
    int unsigned ring_len;
    int unsigned ring_pos;
    int unsigned cells_emitted;
    bit          scan_done;

    t_cell pending_cells[$];

    int         mismatches = 0;
    int         cycle_count = 0;
    int         hold_req = 0;
    int         hold_left = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    logic [15:0] stall_pat = '1;
    logic [3:0]  pat_pos = '0;

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void spiral_reload();
        spiral_row    = int'(cfg_srow);
        spiral_col    = int'(cfg_scol);
        ring_top      = spiral_row;
        ring_bot      = spiral_row + 2;
        ring_lft      = spiral_col;
        ring_rgt      = spiral_col + 2;
        ring_len      = 4;
        ring_pos      = 0;
        cells_emitted = 0;
        scan_done     = 1'b0;
    endfunction

    function automatic void cfg_store(input sssc_pkg::t_reg_idx idx,
                                      input logic [sssc_pkg::APB_DATA_W-1:0] val);
        case (idx)
            sssc_pkg::REG_GRID_ROWS: cfg_rows = val[sssc_pkg::DIM_CFG_W-1:0];
            sssc_pkg::REG_GRID_COLS: cfg_cols = val[sssc_pkg::DIM_CFG_W-1:0];
            sssc_pkg::REG_START_ROW: cfg_srow = val[sssc_pkg::START_W-1:0];
            sssc_pkg::REG_START_COL: cfg_scol = val[sssc_pkg::START_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [sssc_pkg::APB_DATA_W-1:0] cfg_value(
        input sssc_pkg::t_reg_idx idx);
        logic [sssc_pkg::APB_DATA_W-1:0] v;
        v = '0;
        case (idx)
            sssc_pkg::REG_GRID_ROWS: v[sssc_pkg::DIM_CFG_W-1:0] = cfg_rows;
            sssc_pkg::REG_GRID_COLS: v[sssc_pkg::DIM_CFG_W-1:0] = cfg_cols;
            sssc_pkg::REG_START_ROW: v[sssc_pkg::START_W-1:0]   = cfg_srow;
            sssc_pkg::REG_START_COL: v[sssc_pkg::START_W-1:0]   = cfg_scol;
            default: ;
        endcase
        return v;
    endfunction

    // Advance the predicted walk by one position, queue the cell if it is in the grid
    function automatic void spiral_advance(input logic restart);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        t_cell       c;
        rows  = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
        cols  = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
        total = rows * cols;
        if (restart)
            spiral_reload();
        if (total == 0)
            return;
        if (cells_emitted >= total)
            scan_done = 1'b1;
        if (scan_done)
            return;
        if (spiral_row >= 0 && spiral_row < int'(rows) &&
            spiral_col >= 0 && spiral_col < int'(cols)) begin
            c.row   = spiral_row[sssc_pkg::ROW_OUT_W-1:0];
            c.col   = spiral_col[sssc_pkg::ROW_OUT_W-1:0];
            c.index = cells_emitted[sssc_pkg::INDEX_OUT_W-1:0];
            c.last  = (cells_emitted + 1 == total);
            pending_cells.push_back(c);
            cells_emitted++;
            if (cells_emitted >= total)
                scan_done = 1'b1;
        end
        ring_pos++;
        if (ring_pos >= ring_len) begin
            // Grow the ring and enter it on its left column
            ring_top--;
            ring_bot++;
            ring_lft--;
            ring_rgt++;
            spiral_row = ring_bot - 2;
            spiral_col = ring_lft;
            ring_len += 8;
            ring_pos = 0;
            if (ring_top < -RING_LIMIT || ring_lft < -RING_LIMIT ||
                ring_bot > RING_LIMIT || ring_rgt > RING_LIMIT)
                scan_done = 1'b1;
        end else if (spiral_row == ring_top && spiral_col < ring_rgt - 1) begin
            spiral_col++;
        end else if (spiral_col == ring_rgt - 1 && spiral_row < ring_bot - 1) begin
            spiral_row++;
        end else if (spiral_row == ring_bot - 1 && spiral_col > ring_lft) begin
            spiral_col--;
        end else begin
            spiral_row--;
        end
    endfunction

    // Cell checker
    always @(posedge i_clk) begin
        t_cell e;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_cells.size() == 0) begin
                note_mismatch($sformatf("unexpected cell row=%0d col=%0d index=%0d last=%0b",
                                        o_cell_row, o_cell_col, o_cell_index, o_last));
            end else begin
                e = pending_cells.pop_front();
                if (o_cell_row !== e.row)
                    note_mismatch($sformatf("cell %0d row: expected %0d, got %0d",
                                            e.index, e.row, o_cell_row));
                if (o_cell_col !== e.col)
                    note_mismatch($sformatf("cell %0d col: expected %0d, got %0d",
                                            e.index, e.col, o_cell_col));
                if (o_cell_index !== e.index)
                    note_mismatch($sformatf("cell index: expected %0d, got %0d",
                                            e.index, o_cell_index));
                if (o_last !== e.last)
                    note_mismatch($sformatf("cell %0d last: expected %0b, got %0b",
                                            e.index, e.last, o_last));
            end
        end
    end

    // Receiver: long hold-off when requested, otherwise always ready, a random stall pattern or sparse by sink mode
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN: begin
                    i_out_ready <= 1'b1;
                end
                SINK_PATTERN: begin
                    if (pat_pos == 0)
                        stall_pat = $urandom | $urandom;
                    i_out_ready <= stall_pat[pat_pos];
                    pat_pos++;
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_write(input sssc_pkg::t_reg_idx idx,
                             input logic [sssc_pkg::APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cfg_store(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input sssc_pkg::t_reg_idx idx,
                            output logic [sssc_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        logic [sssc_pkg::APB_DATA_W-1:0] rd;
        sssc_pkg::t_reg_idx              idx;
        for (int i = 0; i < 4; i++) begin
            idx = sssc_pkg::t_reg_idx'(i);
            apb_read(idx, rd);
            if (rd !== cfg_value(idx))
                note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
                                        i, cfg_value(idx), rd));
        end
    endtask

    // Write the grid, optionally the start cell, with junk above each field, then read all registers back
    task automatic program_grid(input logic [sssc_pkg::DIM_CFG_W-1:0] rows,
                                input logic [sssc_pkg::DIM_CFG_W-1:0] cols,
                                input logic [sssc_pkg::START_W-1:0] srow,
                                input logic [sssc_pkg::START_W-1:0] scol,
                                input bit write_start);
        logic [sssc_pkg::APB_DATA_W-1:0] junk;
        junk = $urandom;
        apb_write(sssc_pkg::REG_GRID_ROWS,
                  {junk[sssc_pkg::APB_DATA_W-1:sssc_pkg::DIM_CFG_W], rows});
        junk = $urandom;
        apb_write(sssc_pkg::REG_GRID_COLS,
                  {junk[sssc_pkg::APB_DATA_W-1:sssc_pkg::DIM_CFG_W], cols});
        if (write_start) begin
            junk = $urandom;
            apb_write(sssc_pkg::REG_START_ROW,
                      {junk[sssc_pkg::APB_DATA_W-1:sssc_pkg::START_W], srow});
            junk = $urandom;
            apb_write(sssc_pkg::REG_START_COL,
                      {junk[sssc_pkg::APB_DATA_W-1:sssc_pkg::START_W], scol});
        end
        check_regs();
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Offer one step transaction and predict once it is taken
    task automatic offer_step(input logic restart);
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        spiral_advance(restart);
    endtask

    task automatic send_burst(input int count, input int max_gap, input int restart_odds);
        int   burst;
        int   k;
        logic rs;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 16);
            for (int j = 0; j < burst && k < count; j++) begin
                rs = (restart_odds != 0) && ($urandom_range(0, restart_odds - 1) == 0);
                offer_step(rs);
                k++;
            end
            if (max_gap != 0)
                pause_sender($urandom_range(0, max_gap));
        end
    endtask

    // Drain all pending cells, then let a stepless item settle
    task automatic wait_idle();
        pause_sender(1);
        while (pending_cells.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [sssc_pkg::DIM_CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return sssc_pkg::DIM_CFG_W'(MAX_DIM);
            2:       return sssc_pkg::DIM_CFG_W'($urandom_range(MAX_DIM + 1, 2047));
            3:       return '1;
            4, 5, 6, 7: return sssc_pkg::DIM_CFG_W'($urandom_range(1, 16));
            default: return sssc_pkg::DIM_CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [sssc_pkg::START_W-1:0] pick_start(
        input logic [sssc_pkg::DIM_CFG_W-1:0] dim);
        int unsigned d;
        d = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
        case ($urandom_range(0, 15))
            0:       return '1;
            1, 2, 3: return sssc_pkg::START_W'(d + $urandom_range(0, 3));
            default: return (d == 0) ? sssc_pkg::START_W'($urandom_range(0, 3))
                                     : sssc_pkg::START_W'($urandom_range(0, d - 1));
        endcase
    endfunction

    task automatic test_reset_defaults();
        sink_mode = SINK_PATTERN;
        check_regs();
        // 1x1 grid from reset: one cell, then nothing until restart
        offer_step(1'b0);
        offer_step(1'b0);
        offer_step(1'b0);
        offer_step(1'b1);
        offer_step(1'b0);
    endtask

    task automatic test_empty_grid();
        wait_idle();
        program_grid('0, 11'd5, 10'd1, 10'd1, 1'b1);
        offer_step(1'b1);
        offer_step(1'b0);
        wait_idle();
        program_grid(11'd5, '0, 10'd1, 10'd1, 1'b0);
        offer_step(1'b1);
        offer_step(1'b0);
    endtask

    task automatic test_max_grid();
        wait_idle();
        // Saturated rows, far corner start
        program_grid('1, sssc_pkg::DIM_CFG_W'(MAX_DIM), '1, '1, 1'b1);
        offer_step(1'b1);
        repeat (5) offer_step(1'b0);
    endtask

    task automatic test_full_small();
        wait_idle();
        program_grid(11'd2, 11'd2, '0, '0, 1'b1);
        offer_step(1'b1);
        repeat (4) offer_step(1'b0);
    endtask

    task automatic test_shrink_below_count();
        wait_idle();
        program_grid(11'd3, 11'd3, '0, '0, 1'b1);
        offer_step(1'b1);
        offer_step(1'b0);
        offer_step(1'b0);
        wait_idle();
        program_grid(11'd1, 11'd1, '0, '0, 1'b0);
        offer_step(1'b0);
        wait_idle();
        // Enlarging again leaves the walk finished
        program_grid(11'd3, 11'd3, '0, '0, 1'b0);
        offer_step(1'b0);
        offer_step(1'b1);
    endtask

    task automatic test_start_outside();
        wait_idle();
        program_grid(11'd1, 11'd1, 10'd1, 10'd1, 1'b1);
        offer_step(1'b1);
        repeat (6) offer_step(1'b0);
    endtask

    task automatic test_random_walks();
        int                             sent;
        int                             n;
        logic [sssc_pkg::DIM_CFG_W-1:0] rows;
        logic [sssc_pkg::DIM_CFG_W-1:0] cols;
        sent = 0;
        while (sent < RANDOM_STEPS) begin
            wait_idle();
            rows = pick_dim();
            cols = pick_dim();
            program_grid(rows, cols, pick_start(rows), pick_start(cols),
                         $urandom_range(0, 3) != 0);
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            n = $urandom_range(20, 70);
            // Mostly a fresh walk; sometimes keep the old walk under the new grid
            if ($urandom_range(0, 3) != 0)
                offer_step(1'b1);
            send_burst(n, $urandom_range(0, 6), 40);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        program_grid(sssc_pkg::DIM_CFG_W'(MAX_DIM), sssc_pkg::DIM_CFG_W'(MAX_DIM),
                     10'd500, 10'd500, 1'b1);
        sink_mode = SINK_OPEN;
        hold_req = 300;
        offer_step(1'b1);
        send_burst(80, 0, 0);
    endtask

    initial begin
        cfg_rows = sssc_pkg::GRID_DIM_RESET;
        cfg_cols = sssc_pkg::GRID_DIM_RESET;
        cfg_srow = '0;
        cfg_scol = '0;
        spiral_reload();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_empty_grid();
        test_max_grid();
        test_full_small();
        test_shrink_below_count();
        test_start_outside();
        test_random_walks();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_cells.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[spiral_scan_coordinate_generator.f]
+incdir+hw/rtl
hw/rtl/sssc_pkg.sv
hw/rtl/sssc_cfg.sv
hw/rtl/spiral_scan_coordinate_generator.sv
tb/tb_spiral_scan_coordinate_generator.sv
